### hw/rtl/mbaf_pkg.sv
`default_nettype none

package mbaf_pkg;

	// frame layout
	localparam int unsigned FRAME_LEN = 8;
	localparam int unsigned HDR_LEN   = 6;
	localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

	// byte positions of the crc in the frame
	localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(HDR_LEN);
	localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(FRAME_LEN - 1);

	// protocol constants
	localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
	localparam logic [15:0] CRC_INIT          = 16'hFFFF;
	localparam logic [15:0] CRC_POLY          = 16'hA001;
	localparam logic [15:0] REG_NUMBER_RESET  = 16'h00C2;

	// alarm commands
	localparam logic [1:0] CMD_FAST_FLASH = 2'd0;
	localparam logic [1:0] CMD_SLOW_FLASH = 2'd1;
	localparam logic [1:0] CMD_STEADY_ON  = 2'd2;
	localparam logic [1:0] CMD_OFF        = 2'd3;

	// the six bytes ahead of the crc, element 0 sent first
	typedef logic [HDR_LEN-1:0][7:0] hdr_t;

	// register value written for each alarm command
	function automatic logic [15:0] mode_value(input logic [1:0] cmd);
		logic [15:0] v;
		case (cmd)
			CMD_FAST_FLASH: v = 16'h0003;
			CMD_SLOW_FLASH: v = 16'h0004;
			CMD_STEADY_ON:  v = 16'h0005;
			CMD_OFF:        v = 16'h0006;
			default:        v = 16'h0006;
		endcase
		return v;
	endfunction

	// crc-16/modbus update over one byte, lsb first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] acc;
		acc = crc ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (acc[0]) begin
				acc = (acc >> 1) ^ CRC_POLY;
			end else begin
				acc = acc >> 1;
			end
		end
		return acc;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/mbaf_req_if.sv
`default_nettype none

interface mbaf_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] slave_address;
	logic [1:0] command;

	modport source (output valid, output slave_address, output command, input ready);
	modport sink (input valid, input slave_address, input command, output ready);
endinterface

`default_nettype wire

### hw/rtl/mbaf_byte_if.sv
`default_nettype none

interface mbaf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;

	modport source (output valid, output frame_byte, output last_byte, input ready);
	modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

`default_nettype wire

### hw/rtl/mbaf_frame_build.sv
`default_nettype none

module mbaf_frame_build (
	input  wire logic          clk,
	input  wire logic          arst_n,
	mbaf_req_if.sink           request,
	input  wire logic [15:0]   register_number,
	output logic               hdr_valid,
	output mbaf_pkg::hdr_t     hdr,
	input  wire logic          hdr_take
);

	logic        valid_s1;
	logic [7:0]  addr_s1;
	logic [1:0]  cmd_s1;
	logic [15:0] value;

	// one request is held until the serializer takes it
	assign request.ready = !valid_s1 || hdr_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.ready) begin
			valid_s1 <= request.valid;
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			addr_s1 <= request.slave_address;
			cmd_s1  <= request.command;
		end
	end

	// header bytes of the write single register request
	always_comb begin
		value  = mbaf_pkg::mode_value(cmd_s1);
		hdr[0] = addr_s1;
		hdr[1] = mbaf_pkg::FUNC_WRITE_SINGLE;
		hdr[2] = register_number[15:8];
		hdr[3] = register_number[7:0];
		hdr[4] = value[15:8];
		hdr[5] = value[7:0];
	end

	assign hdr_valid = valid_s1;

endmodule

`default_nettype wire

### hw/rtl/mbaf_serializer.sv
`default_nettype none

module mbaf_serializer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          hdr_valid,
	input  wire mbaf_pkg::hdr_t hdr,
	output logic               hdr_take,
	mbaf_byte_if.source        frame
);

	logic                       busy_q;
	logic [mbaf_pkg::IDX_W-1:0] idx_q;
	logic [15:0]                crc_q;
	mbaf_pkg::hdr_t             hdr_q;
	logic                       beat;
	logic                       is_hdr;

	assign beat     = frame.valid && frame.ready;
	assign is_hdr   = idx_q < mbaf_pkg::IDX_CRC_LO;
	assign hdr_take = hdr_valid && (!busy_q || (beat && idx_q == mbaf_pkg::IDX_CRC_HI));

	// frame sequencing and running crc
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			crc_q  <= mbaf_pkg::CRC_INIT;
		end else if (hdr_take) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			crc_q  <= mbaf_pkg::CRC_INIT;
		end else if (beat) begin
			if (idx_q == mbaf_pkg::IDX_CRC_HI) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 1'b1;
			if (is_hdr) begin
				crc_q <= mbaf_pkg::crc16_byte(crc_q, hdr_q[idx_q]);
			end
		end
	end

	// header capture
	always_ff @(posedge clk) begin
		if (hdr_take) begin
			hdr_q <= hdr;
		end
	end

	// output beat selection
	always_comb begin
		frame.valid     = busy_q;
		frame.last_byte = idx_q == mbaf_pkg::IDX_CRC_HI;
		if (is_hdr) begin
			frame.frame_byte = hdr_q[idx_q];
		end else if (idx_q == mbaf_pkg::IDX_CRC_LO) begin
			frame.frame_byte = crc_q[7:0];
		end else begin
			frame.frame_byte = crc_q[15:8];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/modbus_alarm_command_framer.sv
`default_nettype none

// Builds one 8-byte Modbus RTU write single register request for each accepted
// request beat (slave address plus alarm command) and sends it one byte per beat
// on the frame channel: address, 0x06, register number high and low, mode value
// high and low, then the CRC-16/MODBUS low and high byte, with last_byte set on
// the final byte. The first byte is offered once the accepted request has passed
// the request register (valid_s1) and the byte-wide serializer has taken the header
// into hdr_q and busy_q, and one further request is buffered while a frame is being sent, so
// frames follow each other without gaps. The CRC is accumulated one byte per sent
// header byte. register_number (reset 0x00C2) is written through cfg_write_en and
// cfg_write_data and should only change while no frame is pending.
module modbus_alarm_command_framer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write_en,
	input  wire logic [15:0] cfg_write_data,
	mbaf_req_if.sink         request,
	mbaf_byte_if.source      frame
);

	logic [15:0]    register_number_q;
	logic           hdr_valid;
	logic           hdr_take;
	mbaf_pkg::hdr_t hdr;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			register_number_q <= mbaf_pkg::REG_NUMBER_RESET;
		end else if (cfg_write_en) begin
			register_number_q <= cfg_write_data;
		end
	end

	// request register and header build
	mbaf_frame_build u_build (
		.clk             (clk),
		.arst_n          (arst_n),
		.request         (request),
		.register_number (register_number_q),
		.hdr_valid       (hdr_valid),
		.hdr             (hdr),
		.hdr_take        (hdr_take)
	);

	// byte serializer with running crc
	mbaf_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.hdr_valid (hdr_valid),
		.hdr       (hdr),
		.hdr_take  (hdr_take),
		.frame     (frame)
	);

endmodule

`default_nettype wire
